### hw/rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// fpa_pkg: shared types, character codes and digit helpers for the formatter
// no dependencies; used by every module of the formatter

package fpa_pkg;

    localparam int NUM_W  = 17;   // widest number to split: hundredths below 100000
    localparam int Q_W    = 10;   // number / 100, below 1000
    localparam int CH_W   = 6;    // ascii code masked to six bits
    localparam int QUEUE_DEPTH = 2;

    localparam logic [17:0] RECIP_100 = 18'd167773;  // ceil(2^24 / 100)
    localparam int          RECIP_SHIFT = 24;
    localparam logic [5:0]  RECIP_100_SMALL = 6'd41;  // ceil(2^12 / 100), q below 1000
    localparam int          RECIP_SMALL_SHIFT = 12;

    localparam logic [31:0] DEC_LIMIT = 32'd9999;
    localparam logic [31:0] BIN_LIMIT = 32'd255999;   // rounds up to 1000.00

    localparam logic [CH_W-1:0] CH_SPACE = 6'd32;
    localparam logic [CH_W-1:0] CH_STAR  = 6'd42;
    localparam logic [CH_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CH_W-1:0] CH_POINT = 6'd46;
    localparam logic [CH_W-1:0] CH_ZERO  = 6'd48;

    localparam logic MODE_DEC = 1'b0;
    localparam logic MODE_BIN = 1'b1;

    // classified item passed from front to back
    typedef struct packed {
        logic             mode;
        logic             oor;
        logic             neg;
        logic [NUM_W-1:0] num;
    } item_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] ones;
    } dig2_t;

    // two decimal digits of a value below 100
    function automatic dig2_t split2(input logic [6:0] x);
        logic [14:0] prod;
        dig2_t       d;
        prod   = 15'(x) * 15'd205;
        d.tens = prod[14:11];
        d.ones = 4'(x - 7'(d.tens) * 7'd10);
        return d;
    endfunction

    function automatic logic [CH_W-1:0] digit_char(input logic [3:0] d);
        return CH_ZERO + CH_W'(d);
    endfunction

endpackage

### hw/rtl/fpa_front.sv
`timescale 1ns / 1ps
// fpa_front: classifies an incoming value, range check and scaling to an integer
// depends on fpa_pkg

module fpa_front
(
    input  logic               req_type,
    input  logic [31:0]        value,
    output fpa_pkg::item_t     item
);

    logic        neg;
    logic [31:0] mag;
    logic [22:0] h_sum;

    assign neg   = value[31];
    assign mag   = neg ? (32'd0 - value) : value;
    // hundredths, rounded half up: (value * 25 + 32) / 64
    assign h_sum = 23'(value[17:0]) * 23'd25 + 23'd32;

    always_comb
    begin
        item.mode = req_type;
        if (req_type == fpa_pkg::MODE_DEC)
        begin
            item.oor = mag > fpa_pkg::DEC_LIMIT;
            item.neg = neg;
            item.num = item.oor ? '0 : fpa_pkg::NUM_W'(mag[13:0]);
        end
        else
        begin
            item.oor = value >= fpa_pkg::BIN_LIMIT;
            item.neg = 1'b0;
            item.num = item.oor ? '0 : h_sum[22:6];
        end
    end

endmodule

### hw/rtl/fpa_queue.sv
`timescale 1ns / 1ps
// fpa_queue: two-entry item queue between front and back
// depends on fpa_pkg

module fpa_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fpa_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output fpa_pkg::item_t out_item
);

    fpa_pkg::item_t mem_reg [fpa_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = cnt_reg != 2'(fpa_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != 2'd0;
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

### hw/rtl/fpa_back.sv
`timescale 1ns / 1ps
// fpa_back: digit split pipeline and character assembly with output register
// depends on fpa_pkg

module fpa_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fpa_pkg::item_t              in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fpa_pkg::CH_W*6-1:0]  out_chars,
    output logic                        out_oor
);

    // stage 1: number / 100
    logic                    b1_v_reg;
    fpa_pkg::item_t          b1_item_reg;
    logic [fpa_pkg::Q_W-1:0] b1_q_reg;
    // stage 2: remainder and hundreds of the quotient
    logic                    b2_v_reg;
    logic                    b2_mode_reg, b2_oor_reg, b2_neg_reg;
    logic [fpa_pkg::Q_W-1:0] b2_q_reg;
    logic [3:0]              b2_hq_reg;
    logic [6:0]              b2_r_reg;
    // output register
    logic                        out_v_reg;
    logic [fpa_pkg::CH_W*6-1:0]  chars_reg, chars_next;
    logic                        oor_reg;

    logic        out_en, b2_en, b1_en;
    logic [34:0] q_prod;
    logic [15:0] hq_prod;
    logic [fpa_pkg::NUM_W-1:0] r_full;
    logic [fpa_pkg::Q_W-1:0]   lowq_full;
    fpa_pkg::dig2_t hi_d, lo_d;
    logic [fpa_pkg::CH_W-1:0] c0, c1, c2, c3, c4, c5;

    assign out_en   = !out_v_reg || out_ready;
    assign b2_en    = !b2_v_reg || out_en;
    assign b1_en    = !b1_v_reg || b2_en;
    assign in_ready = b1_en;

    assign q_prod  = 35'(in_item.num) * 35'(fpa_pkg::RECIP_100);
    assign hq_prod = 16'(b1_q_reg) * 16'(fpa_pkg::RECIP_100_SMALL);
    assign r_full  = b1_item_reg.num - fpa_pkg::NUM_W'(b1_q_reg) * fpa_pkg::NUM_W'(100);

    assign lowq_full = b2_q_reg - fpa_pkg::Q_W'(b2_hq_reg) * fpa_pkg::Q_W'(100);
    assign hi_d      = fpa_pkg::split2(lowq_full[6:0]);
    assign lo_d      = fpa_pkg::split2(b2_r_reg);

    always_comb
    begin
        if (b2_mode_reg == fpa_pkg::MODE_DEC)
        begin
            if (b2_oor_reg)
            begin
                c0 = fpa_pkg::CH_SPACE; c1 = fpa_pkg::CH_STAR; c2 = fpa_pkg::CH_POINT;
                c3 = fpa_pkg::CH_STAR;  c4 = fpa_pkg::CH_STAR; c5 = fpa_pkg::CH_STAR;
            end
            else
            begin
                c0 = b2_neg_reg ? fpa_pkg::CH_MINUS : fpa_pkg::CH_SPACE;
                c1 = fpa_pkg::digit_char(hi_d.tens);
                c2 = fpa_pkg::CH_POINT;
                c3 = fpa_pkg::digit_char(hi_d.ones);
                c4 = fpa_pkg::digit_char(lo_d.tens);
                c5 = fpa_pkg::digit_char(lo_d.ones);
            end
        end
        else
        begin
            if (b2_oor_reg)
            begin
                c0 = fpa_pkg::CH_STAR;  c1 = fpa_pkg::CH_STAR; c2 = fpa_pkg::CH_STAR;
                c3 = fpa_pkg::CH_POINT; c4 = fpa_pkg::CH_STAR; c5 = fpa_pkg::CH_STAR;
            end
            else
            begin
                // leading blanks for integer parts below 100 and below 10
                c0 = (b2_hq_reg != 4'd0) ? fpa_pkg::digit_char(b2_hq_reg)
                                         : fpa_pkg::CH_SPACE;
                c1 = (b2_q_reg >= fpa_pkg::Q_W'(10)) ? fpa_pkg::digit_char(hi_d.tens)
                                                    : fpa_pkg::CH_SPACE;
                c2 = fpa_pkg::digit_char(hi_d.ones);
                c3 = fpa_pkg::CH_POINT;
                c4 = fpa_pkg::digit_char(lo_d.tens);
                c5 = fpa_pkg::digit_char(lo_d.ones);
            end
        end
        chars_next = {c5, c4, c3, c2, c1, c0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg  <= 1'b0;
            b2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (b1_en)
                b1_v_reg <= in_valid;
            if (b2_en)
                b2_v_reg <= b1_v_reg;
            if (out_en)
                out_v_reg <= b2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_en)
        begin
            b1_item_reg <= in_item;
            b1_q_reg    <= q_prod[fpa_pkg::RECIP_SHIFT +: fpa_pkg::Q_W];
        end
        if (b2_en)
        begin
            b2_mode_reg <= b1_item_reg.mode;
            b2_oor_reg  <= b1_item_reg.oor;
            b2_neg_reg  <= b1_item_reg.neg;
            b2_q_reg    <= b1_q_reg;
            b2_hq_reg   <= hq_prod[fpa_pkg::RECIP_SMALL_SHIFT +: 4];
            b2_r_reg    <= r_full[6:0];
        end
        if (out_en)
        begin
            chars_reg <= chars_next;
            oor_reg   <= b2_oor_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_chars = chars_reg;
    assign out_oor   = oor_reg;

endmodule

### hw/rtl/fixed_point_to_ascii_formatter.sv
`timescale 1ns / 1ps
// fixed_point_to_ascii_formatter: top level, front classifier, item queue, back pipeline
// depends on fpa_pkg, fpa_front, fpa_queue, fpa_back

// Turns one 32-bit fixed-point value into six ASCII display characters.
// tuser selects the format: 0 reads tdata as two's complement thousandths and
// gives sign, digit, point, three digits; 1 reads it as unsigned 1/256 units
// and gives the value rounded half up to hundredths, right aligned with
// leading blanks. Values that do not fit give stars and set tuser on the
// output side. The block takes one item per clock cycle with no gaps: the
// front classifies and scales in the accept cycle, a two-entry queue parts it
// from the back, and the back is a three-register pipeline (divide by 100,
// remainder and hundreds, character assembly into the output register).
// An accepted item passes through its queue entry and then the three back
// registers in order; the queue and pipeline absorb a stalled output without
// dropping the input rate until they fill.

module fixed_point_to_ascii_formatter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [5:0] char_0 .. [35:30] char_5, [39:36] zero
    output logic        m_axis_tuser    // [0] out_of_range
);

    fpa_pkg::item_t front_item;
    fpa_pkg::item_t queue_item;
    logic           queue_valid;
    logic           back_ready;
    logic [fpa_pkg::CH_W*6-1:0] chars;

    // front: range check and scaling, combinational in the accept cycle
    fpa_front u_front
    (
        .req_type (s_axis_tuser),
        .value    (s_axis_tdata),
        .item     (front_item)
    );

    // queue: decouples input acceptance from back-end stalls
    fpa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (back_ready),
        .out_item  (queue_item)
    );

    // back: digit split and character assembly
    fpa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_ready  (back_ready),
        .in_item   (queue_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_chars (chars),
        .out_oor   (m_axis_tuser)
    );

    assign m_axis_tdata = {4'd0, chars};

    // a flagged item always shows a star in the second position
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> chars[11:6] == fpa_pkg::CH_STAR)
        else $error("flagged item without star pattern");

    // every item carries its point in the third or fourth position
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> chars[17:12] == fpa_pkg::CH_POINT ||
                          chars[23:18] == fpa_pkg::CH_POINT)
        else $error("decimal point missing");

    // a minus sign only appears on a value that could be shown
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && chars[5:0] == fpa_pkg::CH_MINUS |-> !m_axis_tuser)
        else $error("minus sign on flagged item");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// testbench: checks fixed_point_to_ascii_formatter against its own display predictor
// depends on fpa_pkg (character codes, mode codes) and the formatter rtl

module testbench;

    localparam int HALF_PERIOD = 2;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CALM_ITEMS = 150;    // tail of the run in which no new idle bursts start on either side
    localparam int DRAIN_CYCLES = 8;    // pipeline is three deep, plus margin
    localparam int DEC_MAX_MAG = 9999;
    localparam int BIN_RAW_LIMIT = 256000;
    localparam int BIN_HUND_LIMIT = 100000;

    typedef struct {
        logic        mode;
        logic [31:0] raw;
    } fixed_item_t;

    typedef struct {
        logic [fpa_pkg::CH_W-1:0] ch [6];
        logic                     oor;
    } display_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] value
    logic        s_axis_tuser = 1'b0;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // [5:0] char_0 .. [35:30] char_5, [39:36] zero
    logic        m_axis_tuser;          // [0] out_of_range

    fixed_item_t pending_q [$];
    display_t    display_q [$];
    fixed_item_t cur_item;
    int          mismatch_count = 0;
    int          send_gap = 0;
    int          send_idle_pct = 20;
    int          sent_count = 0;
    int          sink_stall = 0;
    int          sink_stall_pct = 20;
    int          sink_count = 0;

    fixed_point_to_ascii_formatter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // six display characters and the range flag for one value
    function automatic display_t format_display(input logic mode, input logic [31:0] raw);
        display_t    d;
        logic [31:0] mag;
        logic [37:0] hund;
        logic [31:0] ip;
        logic [31:0] fr;
        d.oor = 1'b0;
        if (mode == fpa_pkg::MODE_DEC)
        begin
            // magnitude of the two's complement thousandths
            mag = raw[31] ? (32'd0 - raw) : raw;
            if (mag > DEC_MAX_MAG)
            begin
                d.ch = '{fpa_pkg::CH_SPACE, fpa_pkg::CH_STAR, fpa_pkg::CH_POINT,
                         fpa_pkg::CH_STAR, fpa_pkg::CH_STAR, fpa_pkg::CH_STAR};
                d.oor = 1'b1;
            end
            else
            begin
                d.ch[0] = raw[31] ? fpa_pkg::CH_MINUS : fpa_pkg::CH_SPACE;
                d.ch[1] = fpa_pkg::CH_ZERO + fpa_pkg::CH_W'(mag / 1000);
                d.ch[2] = fpa_pkg::CH_POINT;
                d.ch[3] = fpa_pkg::CH_ZERO + fpa_pkg::CH_W'((mag / 100) % 10);
                d.ch[4] = fpa_pkg::CH_ZERO + fpa_pkg::CH_W'((mag / 10) % 10);
                d.ch[5] = fpa_pkg::CH_ZERO + fpa_pkg::CH_W'(mag % 10);
            end
        end
        else
        begin
            // raw * 100 / 256 rounded half up, kept wide so nothing wraps
            hund = (38'(raw) * 38'd25 + 38'd32) >> 6;
            if (raw >= BIN_RAW_LIMIT || hund >= BIN_HUND_LIMIT)
            begin
                d.ch = '{fpa_pkg::CH_STAR, fpa_pkg::CH_STAR, fpa_pkg::CH_STAR,
                         fpa_pkg::CH_POINT, fpa_pkg::CH_STAR, fpa_pkg::CH_STAR};
                d.oor = 1'b1;
            end
            else
            begin
                ip = 32'(hund / 100);
                fr = 32'(hund % 100);
                d.ch[0] = (ip >= 100) ? fpa_pkg::CH_ZERO + fpa_pkg::CH_W'(ip / 100)
                                      : fpa_pkg::CH_SPACE;
                d.ch[1] = (ip >= 10) ? fpa_pkg::CH_ZERO + fpa_pkg::CH_W'((ip / 10) % 10)
                                     : fpa_pkg::CH_SPACE;
                d.ch[2] = fpa_pkg::CH_ZERO + fpa_pkg::CH_W'(ip % 10);
                d.ch[3] = fpa_pkg::CH_POINT;
                d.ch[4] = fpa_pkg::CH_ZERO + fpa_pkg::CH_W'(fr / 10);
                d.ch[5] = fpa_pkg::CH_ZERO + fpa_pkg::CH_W'(fr % 10);
            end
        end
        return d;
    endfunction

    task automatic queue_value(input logic mode, input logic [31:0] raw);
        fixed_item_t it;
        it.mode = mode;
        it.raw = raw;
        pending_q.push_back(it);
    endtask

    // mostly in-range values with random content, then boundaries, rounding ties and noise
    task automatic queue_random_values(input int count);
        int          pick;
        logic        mode;
        logic [31:0] raw;
        for (int n = 0; n < count; n++)
        begin
            mode = logic'($urandom_range(1));
            pick = $urandom_range(99);
            if (mode == fpa_pkg::MODE_DEC)
            begin
                if (pick < 60)
                    raw = 32'($urandom_range(2 * DEC_MAX_MAG) - DEC_MAX_MAG);
                else if (pick < 75)
                    raw = $urandom_range(1) ? 32'($urandom_range(10010, 9990))
                                            : 32'd0 - 32'($urandom_range(10010, 9990));
                else if (pick < 85)
                    raw = 32'($urandom_range(40) - 20);
                else
                    raw = $urandom;
            end
            else
            begin
                if (pick < 55)
                    raw = 32'($urandom_range(BIN_RAW_LIMIT - 1));
                else if (pick < 70)
                    raw = 32'($urandom_range(256010, 255980));
                else if (pick < 78)
                    raw = 32'($urandom_range(300));
                else if (pick < 86)
                    // around 10.00 and 100.00 where a leading blank turns into a digit
                    raw = $urandom_range(1) ? 32'($urandom_range(2570, 2550))
                                            : 32'($urandom_range(25610, 25590));
                else
                    raw = $urandom;
            end
            queue_value(mode, raw);
        end
    endtask

    // driver: presents queued items, holds them until accepted, idles in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                display_q.push_back(format_display(cur_item.mode, cur_item.raw));
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_q.size() == 0)
                    s_axis_tvalid <= 1'b0;
                else if (pending_q.size() > CALM_ITEMS && $urandom_range(99) < send_idle_pct)
                begin
                    send_gap = $urandom_range(13, 1) - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    cur_item = pending_q.pop_front();
                    s_axis_tdata <= cur_item.raw;
                    s_axis_tuser <= cur_item.mode;
                    s_axis_tvalid <= 1'b1;
                    sent_count = sent_count + 1;
                    // change how busy the sender is now and then, zero included
                    if (sent_count % 64 == 0)
                        send_idle_pct = $urandom_range(2) * 25;
                end
            end
        end
    end

    // monitor: stalls the output side in bursts and checks every accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (display_q.size() == 0)
                begin
                    $error("result with no item waiting: tdata %h tuser %b",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    display_t exp_disp;
                    exp_disp = display_q.pop_front();
                    for (int i = 0; i < 6; i++)
                    begin
                        if (m_axis_tdata[i*fpa_pkg::CH_W +: fpa_pkg::CH_W] !== exp_disp.ch[i])
                        begin
                            $error("char_%0d: expected %0d, actual %0d", i,
                                   exp_disp.ch[i],
                                   m_axis_tdata[i*fpa_pkg::CH_W +: fpa_pkg::CH_W]);
                            mismatch_count = mismatch_count + 1;
                        end
                    end
                    if (m_axis_tuser !== exp_disp.oor)
                    begin
                        $error("out_of_range: expected %0d, actual %0d",
                               exp_disp.oor, m_axis_tuser);
                        mismatch_count = mismatch_count + 1;
                    end
                end
                sink_count = sink_count + 1;
                if (sink_count % 64 == 0)
                    sink_stall_pct = $urandom_range(2) * 25;
            end
            if (sink_stall > 0)
            begin
                sink_stall = sink_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (pending_q.size() > CALM_ITEMS && $urandom_range(99) < sink_stall_pct)
            begin
                sink_stall = $urandom_range(13, 1) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        // decimal: zero, extremes of the range, just outside, the most negative pattern
        queue_value(fpa_pkg::MODE_DEC, 32'd0);
        queue_value(fpa_pkg::MODE_DEC, 32'd9999);
        queue_value(fpa_pkg::MODE_DEC, 32'd0 - 32'd9999);
        queue_value(fpa_pkg::MODE_DEC, 32'd10000);
        queue_value(fpa_pkg::MODE_DEC, 32'd0 - 32'd10000);
        queue_value(fpa_pkg::MODE_DEC, 32'h8000_0000);
        queue_value(fpa_pkg::MODE_DEC, 32'h7fff_ffff);
        queue_value(fpa_pkg::MODE_DEC, 32'hffff_ffff);
        queue_value(fpa_pkg::MODE_DEC, 32'd1);
        queue_value(fpa_pkg::MODE_DEC, 32'd1234);
        queue_value(fpa_pkg::MODE_DEC, 32'd0 - 32'd5678);
        // binary: zero, smallest step, a rounding tie, digit boundaries
        queue_value(fpa_pkg::MODE_BIN, 32'd0);
        queue_value(fpa_pkg::MODE_BIN, 32'd1);
        queue_value(fpa_pkg::MODE_BIN, 32'd32);
        queue_value(fpa_pkg::MODE_BIN, 32'd2559);
        queue_value(fpa_pkg::MODE_BIN, 32'd2560);
        queue_value(fpa_pkg::MODE_BIN, 32'd25599);
        queue_value(fpa_pkg::MODE_BIN, 32'd25600);
        // rounding up to 1000.00 saturates, as does anything from 256000 up
        queue_value(fpa_pkg::MODE_BIN, 32'd255998);
        queue_value(fpa_pkg::MODE_BIN, 32'd255999);
        queue_value(fpa_pkg::MODE_BIN, 32'd256000);
        queue_value(fpa_pkg::MODE_BIN, 32'hffff_ffff);
        queue_value(fpa_pkg::MODE_BIN, 32'h8000_0000);
        queue_random_values(RANDOM_ITEMS);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (display_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_queue.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_to_ascii_formatter.sv
test/testbench.sv
